>>> sv/capped_adjacency_table_macros.svh
// assertion macros for the capped adjacency table
`ifndef CAPPED_ADJACENCY_TABLE_MACROS_SVH
`define CAPPED_ADJACENCY_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CAT_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("capped adjacency table check failed");

// next-cycle implication, checked out of reset
`define CAT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("capped adjacency table check failed");

`endif

>>> sv/cat_pkg.sv
// shared constants, codes and types of the capped adjacency table
package cat_pkg;

	localparam int MAX_NODES  = 64;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int MAX_DEGREE = 16;
	localparam int DEG_W      = $clog2(MAX_DEGREE);
	localparam int BUF_N      = MAX_DEGREE + 1;
	localparam int BUF_W      = $clog2(BUF_N + 1);
	localparam int CAP_W      = 5;
	localparam int FREE_W     = NODE_W + 1;
	localparam int ID_W       = 32;
	localparam int WT_W       = 32;
	localparam int EDGE_AW    = NODE_W + DEG_W;

	typedef enum logic [1:0] {
		OP_UPSERT  = 2'd0,
		OP_QUERY   = 2'd1,
		OP_COMPACT = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_DECIDE,
		S_ADD_A,
		S_ADD_B,
		S_EW_CNT,
		S_EW_CNTW,
		S_EW_LRD,
		S_EW_LDAT,
		S_EW_INS,
		S_EW_RANK,
		S_EW_WB,
		S_EW_CW,
		S_CMP,
		S_CMP_ADV,
		S_Q_CNT,
		S_Q_CNTW,
		S_Q_RD,
		S_Q_DAT,
		S_RESP
	} state_t;

	typedef logic [ID_W-1:0] id_t;
	typedef logic [WT_W-1:0] wt_t;

endpackage

>>> sv/cat_rank.sv
// rank of one buffered edge against the whole list, and its keep decision under the cap
module cat_rank (
	input  cat_pkg::id_t               nb [cat_pkg::BUF_N],
	input  cat_pkg::wt_t               wt [cat_pkg::BUF_N],
	input  logic [cat_pkg::BUF_W-1:0]  n,
	input  logic [cat_pkg::BUF_W-1:0]  sel,
	input  logic [cat_pkg::CAP_W-1:0]  cap,
	output logic                       keep
);

	function automatic logic [cat_pkg::WT_W-1:0] mag(input cat_pkg::wt_t w);
		logic [cat_pkg::WT_W-1:0] r;
		r = w[cat_pkg::WT_W-1] ? (~w + 1'b1) : w;
		return r;
	endfunction

	logic [cat_pkg::WT_W-1:0]  sel_mag;
	cat_pkg::id_t              sel_nb;
	logic [cat_pkg::WT_W-1:0]  lane_mag [cat_pkg::BUF_N];
	logic [cat_pkg::BUF_N-1:0] better;
	logic [cat_pkg::BUF_W-1:0] rank;

	always_comb begin
		sel_mag = mag(wt[sel]);
		sel_nb  = nb[sel];
		for (int j = 0; j < cat_pkg::BUF_N; j++) begin
			lane_mag[j] = mag(wt[j]);
			better[j]   = (cat_pkg::BUF_W'(j) < n) &&
				((lane_mag[j] > sel_mag) || ((lane_mag[j] == sel_mag) && (nb[j] < sel_nb)));
		end
		rank = cat_pkg::BUF_W'($countones(better));
		keep = rank < cat_pkg::BUF_W'(cap);
	end

endmodule

>>> sv/capped_adjacency_table.sv
// capped adjacency table: top level with node scan, edge list editor and query output
//
// input channel s_*: one beat per command, opcode in s_tuser; s_tready is high only
// while the block is idle. output channel m_*: one beat per result, tlast on the
// final one; a query with edges gives one beat per edge, any other result one beat.
// every command first scans the 64-entry node key memory, except compact and
// clear. an edge list edit on a node loads its edges one by one, updates the
// weight of the new edge or inserts it in neighbor order, ranks every edge and
// writes back those kept under the cap, then writes the new edge count. an upsert
// adds its missing nodes and edits the lists of both nodes; a query reads the edge
// count and then each edge; compact edits each valid node without inserting;
// clear goes straight to its response. one command is in work at a time.
// the output beat sits in a register: a new command is taken while it waits, and
// a stalled receiver only holds the block when the next result is ready.
// cfg_we writes the degree cap; the user must do it only while idle (not enforced).
// reset empties the node table and sets the cap to zero (full depth); no memory
// sweep is needed.
`include "capped_adjacency_table_macros.svh"

module capped_adjacency_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,   // degree_cap
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,     // node_a_id, node_b_id, weight
	input  logic [1:0]  s_tuser,     // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,     // neighbor_id, edge_weight
	output logic [2:0]  m_tuser,     // status, edge_valid
	output logic        m_tlast
);

	cat_pkg::state_t state_q, state_d;

	logic [cat_pkg::CAP_W-1:0]     cap_q;
	logic [cat_pkg::CAP_W-1:0]     eff_cap;
	logic [cat_pkg::MAX_NODES-1:0] nv_q;

	cat_pkg::op_t   op_q;
	cat_pkg::id_t   a_q, b_q, nbr_q;
	cat_pkg::wt_t   w_q;
	cat_pkg::stat_t status_q;

	logic [cat_pkg::NODE_W-1:0] scan_i_q, scan_idx_s1;
	logic                       scan_v_s1;
	logic                       fa_q, fb_q;
	logic [cat_pkg::NODE_W-1:0] fa_idx_q, fb_idx_q, f1_q, f2_q;
	logic [cat_pkg::FREE_W-1:0] free_q;
	logic [cat_pkg::NODE_W-1:0] ia_q, ib_q, node_q, c_q;
	logic                       add_a_q, add_b_q, pass_q, ins_q, found_q;

	logic [cat_pkg::BUF_W-1:0]  n_q, k_q, r_q, wp_q;
	cat_pkg::id_t               buf_nb_q [cat_pkg::BUF_N];
	cat_pkg::wt_t               buf_wt_q [cat_pkg::BUF_N];
	logic [cat_pkg::BUF_N-1:0]  keep_q, lt, lt_prev;
	logic                       keep;

	// memories
	cat_pkg::id_t                key_mem [cat_pkg::MAX_NODES];
	cat_pkg::id_t                key_rd_q;
	logic [cat_pkg::BUF_W-1:0]   cnt_mem [cat_pkg::MAX_NODES];
	logic [cat_pkg::BUF_W-1:0]   cnt_rd_q;
	logic [2*cat_pkg::ID_W-1:0]  edge_mem [cat_pkg::MAX_NODES * cat_pkg::MAX_DEGREE];
	logic [2*cat_pkg::ID_W-1:0]  edge_rd_q;

	logic                        key_we, cnt_we, edge_re, edge_we, out_load;
	logic [cat_pkg::NODE_W-1:0]  key_waddr, cnt_waddr;
	cat_pkg::id_t                key_wdata;
	logic [cat_pkg::BUF_W-1:0]   cnt_wdata;
	logic [cat_pkg::EDGE_AW-1:0] edge_raddr, edge_waddr;

	cat_pkg::id_t   rd_nb;
	cat_pkg::wt_t   rd_wt;
	logic           match_now, found_now, out_free;
	logic [1:0]     need;
	logic [cat_pkg::NODE_W-1:0] ia_d, ib_d;

	logic           m_tvalid_q, m_ev_q, m_last_q;
	cat_pkg::stat_t m_status_q;
	cat_pkg::id_t   m_nb_q;
	cat_pkg::wt_t   m_wt_q;

	assign eff_cap  = (cap_q == '0 || cap_q > cat_pkg::CAP_W'(cat_pkg::MAX_DEGREE)) ?
		cat_pkg::CAP_W'(cat_pkg::MAX_DEGREE) : cap_q;
	assign rd_nb     = edge_rd_q[cat_pkg::ID_W-1:0];
	assign rd_wt     = edge_rd_q[2*cat_pkg::ID_W-1:cat_pkg::ID_W];
	assign match_now = ins_q && (rd_nb == nbr_q);
	assign found_now = found_q || match_now;
	assign out_free  = !m_tvalid_q || m_tready;
	assign need      = {1'b0, !fa_q} + {1'b0, (!fb_q && (b_q != a_q))};
	assign ia_d      = fa_q ? fa_idx_q : f1_q;
	assign ib_d      = (b_q == a_q) ? ia_d : (fb_q ? fb_idx_q : (fa_q ? f1_q : f2_q));

	assign s_tready = (state_q == cat_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_wt_q, m_nb_q};
	assign m_tuser  = {m_ev_q, m_status_q};
	assign m_tlast  = m_last_q;

	assign edge_raddr = {node_q, k_q[cat_pkg::DEG_W-1:0]};
	assign edge_waddr = {node_q, wp_q[cat_pkg::DEG_W-1:0]};

	always_comb begin
		lt_prev[0] = 1'b1;
		for (int j = 0; j < cat_pkg::BUF_N; j++) begin
			lt[j] = (cat_pkg::BUF_W'(j) < n_q) && (buf_nb_q[j] < nbr_q);
		end
		for (int j = 1; j < cat_pkg::BUF_N; j++) begin
			lt_prev[j] = lt[j-1];
		end
	end

	cat_rank u_rank (
		.nb   (buf_nb_q),
		.wt   (buf_wt_q),
		.n    (n_q),
		.sel  (r_q),
		.cap  (eff_cap),
		.keep (keep)
	);

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		key_we    = 1'b0;
		key_waddr = ia_q;
		key_wdata = a_q;
		cnt_we    = 1'b0;
		cnt_waddr = node_q;
		cnt_wdata = '0;
		edge_re   = 1'b0;
		edge_we   = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			cat_pkg::S_IDLE: begin
				if (s_tvalid) begin
					unique case (cat_pkg::op_t'(s_tuser)) inside
						cat_pkg::OP_UPSERT, cat_pkg::OP_QUERY: state_d = cat_pkg::S_SCAN;
						cat_pkg::OP_COMPACT: state_d = cat_pkg::S_CMP;
						cat_pkg::OP_CLEAR: state_d = cat_pkg::S_RESP;
						default: state_d = cat_pkg::S_RESP;
					endcase
				end
			end
			cat_pkg::S_SCAN: begin
				if (scan_i_q == cat_pkg::NODE_W'(cat_pkg::MAX_NODES - 1))
					state_d = cat_pkg::S_SCAN_END;
			end
			cat_pkg::S_SCAN_END: state_d = cat_pkg::S_DECIDE;
			cat_pkg::S_DECIDE: begin
				if (op_q == cat_pkg::OP_QUERY)
					state_d = fa_q ? cat_pkg::S_Q_CNT : cat_pkg::S_RESP;
				else if (cat_pkg::FREE_W'(need) > free_q)
					state_d = cat_pkg::S_RESP;
				else
					state_d = cat_pkg::S_ADD_A;
			end
			cat_pkg::S_ADD_A: begin
				key_we    = add_a_q;
				key_waddr = ia_q;
				key_wdata = a_q;
				cnt_we    = add_a_q;
				cnt_waddr = ia_q;
				state_d   = cat_pkg::S_ADD_B;
			end
			cat_pkg::S_ADD_B: begin
				key_we    = add_b_q;
				key_waddr = ib_q;
				key_wdata = b_q;
				cnt_we    = add_b_q;
				cnt_waddr = ib_q;
				state_d   = cat_pkg::S_EW_CNT;
			end
			cat_pkg::S_EW_CNT: state_d = cat_pkg::S_EW_CNTW;
			cat_pkg::S_EW_CNTW: begin
				if (cnt_rd_q != '0)
					state_d = cat_pkg::S_EW_LRD;
				else if (ins_q)
					state_d = cat_pkg::S_EW_INS;
				else
					state_d = cat_pkg::S_EW_CW;
			end
			cat_pkg::S_EW_LRD: begin
				edge_re = 1'b1;
				state_d = cat_pkg::S_EW_LDAT;
			end
			cat_pkg::S_EW_LDAT: begin
				if ((k_q + cat_pkg::BUF_W'(1)) == n_q)
					state_d = (ins_q && !found_now) ? cat_pkg::S_EW_INS : cat_pkg::S_EW_RANK;
				else
					state_d = cat_pkg::S_EW_LRD;
			end
			cat_pkg::S_EW_INS: state_d = cat_pkg::S_EW_RANK;
			cat_pkg::S_EW_RANK: begin
				if ((r_q + cat_pkg::BUF_W'(1)) == n_q)
					state_d = cat_pkg::S_EW_WB;
			end
			cat_pkg::S_EW_WB: begin
				edge_we = keep_q[r_q];
				if ((r_q + cat_pkg::BUF_W'(1)) == n_q)
					state_d = cat_pkg::S_EW_CW;
			end
			cat_pkg::S_EW_CW: begin
				cnt_we    = 1'b1;
				cnt_waddr = node_q;
				cnt_wdata = wp_q;
				if (op_q == cat_pkg::OP_COMPACT)
					state_d = cat_pkg::S_CMP_ADV;
				else if (!pass_q)
					state_d = cat_pkg::S_EW_CNT;
				else
					state_d = cat_pkg::S_RESP;
			end
			cat_pkg::S_CMP: begin
				state_d = nv_q[c_q] ? cat_pkg::S_EW_CNT : cat_pkg::S_CMP_ADV;
			end
			cat_pkg::S_CMP_ADV: begin
				state_d = (c_q == cat_pkg::NODE_W'(cat_pkg::MAX_NODES - 1)) ?
					cat_pkg::S_RESP : cat_pkg::S_CMP;
			end
			cat_pkg::S_Q_CNT: state_d = cat_pkg::S_Q_CNTW;
			cat_pkg::S_Q_CNTW: begin
				state_d = (cnt_rd_q == '0) ? cat_pkg::S_RESP : cat_pkg::S_Q_RD;
			end
			cat_pkg::S_Q_RD: begin
				edge_re = 1'b1;
				state_d = cat_pkg::S_Q_DAT;
			end
			cat_pkg::S_Q_DAT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ((k_q + cat_pkg::BUF_W'(1)) == n_q) ?
						cat_pkg::S_IDLE : cat_pkg::S_Q_RD;
				end
			end
			cat_pkg::S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = cat_pkg::S_IDLE;
				end
			end
			default: state_d = cat_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cat_pkg::S_IDLE;
			cap_q      <= '0;
			nv_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (s_tvalid && s_tready && cat_pkg::op_t'(s_tuser) == cat_pkg::OP_CLEAR)
				nv_q <= '0;
			if (state_q == cat_pkg::S_ADD_A && add_a_q)
				nv_q[ia_q] <= 1'b1;
			if (state_q == cat_pkg::S_ADD_B && add_b_q)
				nv_q[ib_q] <= 1'b1;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		scan_v_s1   <= (state_q == cat_pkg::S_SCAN);
		scan_idx_s1 <= scan_i_q;

		if (s_tvalid && s_tready) begin
			op_q     <= cat_pkg::op_t'(s_tuser);
			a_q      <= s_tdata[31:0];
			b_q      <= s_tdata[63:32];
			w_q      <= s_tdata[95:64];
			scan_i_q <= '0;
			fa_q     <= 1'b0;
			fb_q     <= 1'b0;
			free_q   <= '0;
			c_q      <= '0;
			status_q <= cat_pkg::STAT_OK;
		end

		if (state_q == cat_pkg::S_SCAN)
			scan_i_q <= scan_i_q + 1'b1;

		if (scan_v_s1) begin
			if (!nv_q[scan_idx_s1]) begin
				if (free_q == cat_pkg::FREE_W'(0))
					f1_q <= scan_idx_s1;
				if (free_q == cat_pkg::FREE_W'(1))
					f2_q <= scan_idx_s1;
				free_q <= free_q + 1'b1;
			end else begin
				if (key_rd_q == a_q) begin
					fa_q     <= 1'b1;
					fa_idx_q <= scan_idx_s1;
				end
				if (key_rd_q == b_q) begin
					fb_q     <= 1'b1;
					fb_idx_q <= scan_idx_s1;
				end
			end
		end

		unique case (state_q)
			cat_pkg::S_DECIDE: begin
				node_q  <= fa_idx_q;
				ia_q    <= ia_d;
				ib_q    <= ib_d;
				add_a_q <= !fa_q;
				add_b_q <= !fb_q && (b_q != a_q);
				if (op_q == cat_pkg::OP_QUERY) begin
					if (!fa_q)
						status_q <= cat_pkg::STAT_NOT_FOUND;
				end else if (cat_pkg::FREE_W'(need) > free_q) begin
					status_q <= cat_pkg::STAT_FULL;
				end
			end
			cat_pkg::S_ADD_B: begin
				node_q <= ia_q;
				nbr_q  <= b_q;
				pass_q <= 1'b0;
				ins_q  <= 1'b1;
			end
			cat_pkg::S_EW_CNTW: begin
				n_q     <= cnt_rd_q;
				k_q     <= '0;
				wp_q    <= '0;
				r_q     <= '0;
				found_q <= 1'b0;
			end
			cat_pkg::S_EW_LDAT: begin
				buf_nb_q[k_q] <= rd_nb;
				buf_wt_q[k_q] <= match_now ? w_q : rd_wt;
				found_q       <= found_now;
				k_q           <= k_q + 1'b1;
				r_q           <= '0;
			end
			cat_pkg::S_EW_INS: begin
				if (lt_prev[0] && !lt[0]) begin
					buf_nb_q[0] <= nbr_q;
					buf_wt_q[0] <= w_q;
				end
				for (int j = 1; j < cat_pkg::BUF_N; j++) begin
					if (!lt[j]) begin
						if (lt_prev[j]) begin
							buf_nb_q[j] <= nbr_q;
							buf_wt_q[j] <= w_q;
						end else begin
							buf_nb_q[j] <= buf_nb_q[j-1];
							buf_wt_q[j] <= buf_wt_q[j-1];
						end
					end
				end
				n_q <= n_q + 1'b1;
				r_q <= '0;
			end
			cat_pkg::S_EW_RANK: begin
				keep_q[r_q] <= keep;
				r_q <= ((r_q + cat_pkg::BUF_W'(1)) == n_q) ? '0 : r_q + 1'b1;
			end
			cat_pkg::S_EW_WB: begin
				if (keep_q[r_q])
					wp_q <= wp_q + 1'b1;
				r_q <= r_q + 1'b1;
			end
			cat_pkg::S_EW_CW: begin
				if (op_q != cat_pkg::OP_COMPACT && !pass_q) begin
					node_q <= ib_q;
					nbr_q  <= a_q;
					pass_q <= 1'b1;
				end
			end
			cat_pkg::S_CMP: begin
				node_q <= c_q;
				ins_q  <= 1'b0;
			end
			cat_pkg::S_CMP_ADV: begin
				c_q <= c_q + 1'b1;
			end
			cat_pkg::S_Q_CNTW: begin
				n_q <= cnt_rd_q;
				k_q <= '0;
			end
			cat_pkg::S_Q_DAT: begin
				if (out_free)
					k_q <= k_q + 1'b1;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			if (state_q == cat_pkg::S_Q_DAT) begin
				m_status_q <= cat_pkg::STAT_OK;
				m_ev_q     <= 1'b1;
				m_nb_q     <= rd_nb;
				m_wt_q     <= rd_wt;
				m_last_q   <= (k_q + cat_pkg::BUF_W'(1)) == n_q;
			end else begin
				m_status_q <= status_q;
				m_ev_q     <= 1'b0;
				m_nb_q     <= '0;
				m_wt_q     <= '0;
				m_last_q   <= 1'b1;
			end
		end
	end

	// node key memory
	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_waddr] <= key_wdata;
		key_rd_q <= key_mem[scan_i_q];
	end

	// edge count memory
	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd_q <= cnt_mem[node_q];
	end

	// edge list memory, neighbor in the low half
	always_ff @(posedge clk) begin
		if (edge_we)
			edge_mem[edge_waddr] <= {buf_wt_q[r_q], buf_nb_q[r_q]};
		if (edge_re)
			edge_rd_q <= edge_mem[edge_raddr];
	end

	`CAT_ASSERT_NEXT(a_leave_idle, s_tvalid && s_tready, !s_tready)
	`CAT_ASSERT_IMPLY(a_cnt_cap, state_q == cat_pkg::S_EW_CW, wp_q <= eff_cap)
	`CAT_ASSERT_IMPLY(a_wb_bound, state_q == cat_pkg::S_EW_WB, wp_q <= r_q)
	`CAT_ASSERT_IMPLY(a_q_index, state_q == cat_pkg::S_Q_DAT, k_q < n_q)

endmodule
